// ===== hdl/multichannel_fader_smoother_defines.svh =====
// assertion macros for the fader smoother
`ifndef MULTICHANNEL_FADER_SMOOTHER_DEFINES_SVH
`define MULTICHANNEL_FADER_SMOOTHER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MFS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mfs_pkg.sv =====
// package for the fader smoother: widths, codes and the alpha rom
`default_nettype none

package mfs_pkg;

   localparam int MAX_MOTORS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int FADER_W   = 14;
   localparam int DIAL_W    = 7;
   localparam int CHAN_W    = 3;
   localparam int MOTOR_W   = 5;
   localparam int CNT_W     = 6;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 24;

   localparam logic [CNT_W-1:0]   CNT_RESET = CNT_W'(8);
   localparam logic [FADER_W-1:0] FADER_MAX = {FADER_W{1'b1}};

   // alpha is unsigned Q0.16, one extra bit for exactly 1.0
   localparam int ALPHA_FRAC  = 16;
   localparam int ALPHA_W     = ALPHA_FRAC + 1;
   localparam int DIAL_DEPTH  = 1 << DIAL_W;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC;
   localparam logic [ALPHA_W-1:0] ALPHA_MIN = ALPHA_W'(66);

   localparam logic CMD_CHANNEL = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   // elaboration-time build of alpha per dial setting (dt = 5 ms, tau from dial)
   function automatic logic [ALPHA_W*DIAL_DEPTH-1:0] build_alpha_rom();
      logic [ALPHA_W*DIAL_DEPTH-1:0] rom;
      logic [127:0] x;
      logic [127:0] dd;
      logic [127:0] num;
      logic [127:0] rem;
      logic [127:0] y2;
      logic [127:0] y3;
      logic [127:0] y4;
      logic [127:0] e;
      logic [127:0] eq;
      logic [127:0] a;
      int d;
      int i;
      int k;
      int b;
      rom = '0;
      for (d = 0; d < DIAL_DEPTH; d++) begin
         if (d == 0) begin
            a = 128'(ALPHA_ONE);
         end else begin
            dd  = 128'(600) * 128'(d) * 128'(d);
            num = 128'd16129 << 32;
            // restoring long division, the quotient fits in 47 bits
            x   = '0;
            rem = '0;
            for (b = 46; b >= 0; b--) begin
               rem = {rem[126:0], num[b]};
               if (rem >= dd) begin
                  rem  = rem - dd;
                  x[b] = 1'b1;
               end
            end
            if (x >= (128'd16 << 32)) begin
               a = 128'(ALPHA_ONE);
            end else begin
               k = 0;
               for (i = 0; i < 16; i++) begin
                  if (x >= (128'd1 << 28)) begin
                     x = x >> 1;
                     k = k + 1;
                  end
               end
               y2 = (x * x) >> 32;
               y3 = (y2 * x) >> 32;
               y4 = (y3 * x) >> 32;
               e  = (128'd1 << 32) - x + y2 / 2 - y3 / 6 + y4 / 24;
               e  = e & ((128'd1 << 64) - 128'd1);
               for (i = 0; i < 16; i++) begin
                  if (i < k) e = (e * e) >> 32;
               end
               eq = (e + (128'd1 << 15)) >> 16;
               a  = (eq >= 128'(ALPHA_ONE)) ? 128'd0 : 128'(ALPHA_ONE) - eq;
               if (a < 128'(ALPHA_MIN)) a = 128'(ALPHA_MIN);
            end
         end
         rom[d*ALPHA_W +: ALPHA_W] = a[ALPHA_W-1:0];
      end
      return rom;
   endfunction

   localparam logic [ALPHA_W*DIAL_DEPTH-1:0] ALPHA_ROM = build_alpha_rom();

endpackage

`default_nettype wire

// ===== hdl/mfs_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module mfs_ram import mfs_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = MAX_MOTORS_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/multichannel_fader_smoother.sv =====
// Multichannel fader smoother, top level.
// Channel transfer: state written at the accepting edge.
// Tick transfer: walks min(count, MAX_MOTORS) motor slots one per cycle through the state
// rams; no new transfer is taken until the walk and the read/evaluate/multiply stages drain.
// The walk and the read/evaluate/multiply/write-back pipeline stall on rsp_tready.
// Synchronous reset clears flags, pipeline and sets motor count to 8; rams are not cleared.
`default_nettype none
`include "multichannel_fader_smoother_defines.svh"

module multichannel_fader_smoother import mfs_pkg::*; #(
   parameter int MAX_MOTORS = MAX_MOTORS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // frame_start, channel, select_button, bank_low, bank_high, fader_raw, dial_raw, zero pad
   input  wire logic [REQ_W-1:0] req_tdata,
   // cmd
   input  wire logic             req_tuser,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // motor slot, smoothed_value, zero pad
   output logic      [RSP_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic             csr_wr_en,
   input  wire logic [CNT_W-1:0] csr_wr_data
);

   localparam int IW      = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
   localparam int CUR_W   = FADER_W + FRAC_BITS;
   localparam int PROD_W  = CUR_W + ALPHA_FRAC;
   localparam int TD_W    = FADER_W + DIAL_W;
   localparam logic [CUR_W-1:0]  HALF_LSB   = CUR_W'(1) << (FRAC_BITS - 1);
   localparam logic [PROD_W:0]   ALPHA_HALF = (PROD_W + 1)'(1) << (ALPHA_FRAC - 1);
   localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_MOTORS);

   // request fields
   logic                 req_frame_start;
   logic [CHAN_W-1:0]    req_channel;
   logic                 req_select;
   logic                 req_bank_low;
   logic                 req_bank_high;
   logic [FADER_W-1:0]   req_fader;
   logic [DIAL_W-1:0]    req_dial;
   logic [MOTOR_W-1:0]   req_motor;

   assign req_frame_start = req_tdata[0];
   assign req_channel     = req_tdata[3:1];
   assign req_select      = req_tdata[4];
   assign req_bank_low    = req_tdata[5];
   assign req_bank_high   = req_tdata[6];
   assign req_fader       = req_tdata[20:7];
   assign req_dial        = req_tdata[27:21];
   assign req_motor       = {req_bank_high, req_bank_low, req_channel};

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      eff_count;
   logic [MAX_MOTORS-1:0] active_ff, active_in;
   logic [MAX_MOTORS-1:0] started_ff, started_in;

   logic walk_ff;
   logic [CNT_W-1:0] idx_ff;

   logic             rd_valid_ff;
   logic [IW-1:0]    rd_idx_ff;
   logic             rd_last_ff;

   logic             ev_valid_ff;
   logic [IW-1:0]    ev_idx_ff;
   logic             ev_last_ff;
   logic [CUR_W-1:0] ev_tgt_ff, ev_tgt_in;
   logic [CUR_W-1:0] ev_cur_ff;
   logic [CUR_W-1:0] ev_mag_ff, ev_mag_in;
   logic             ev_up_ff, ev_up_in;
   logic             ev_snap_ff, ev_snap_in;
   logic [ALPHA_FRAC-1:0] ev_alpha_ff;

   logic              mul_valid_ff;
   logic [IW-1:0]     mul_idx_ff;
   logic              mul_last_ff;
   logic [CUR_W-1:0]  mul_tgt_ff;
   logic [CUR_W-1:0]  mul_cur_ff;
   logic              mul_up_ff;
   logic              mul_snap_ff;
   logic [PROD_W-1:0] mul_prod_ff;

   logic               out_valid_ff;
   logic [MOTOR_W-1:0] out_idx_ff;
   logic [FADER_W-1:0] out_val_ff, out_val_in;
   logic               out_last_ff;

   logic req_accept;
   logic is_channel;
   logic is_tick;
   logic motor_ok;
   logic adv;
   logic issue;
   logic later_active;

   logic [TD_W-1:0]  td_rd_data;
   logic [CUR_W-1:0] cur_rd_data;
   logic [ALPHA_W-1:0] alpha_rd;

   logic [PROD_W:0]  step_sum;
   logic [CUR_W:0]   step;
   logic [CUR_W-1:0] new_cur;
   logic [CUR_W:0]   round_sum;
   logic [FADER_W:0] rounded;

   logic             wb_en;
   logic             ch_cur_wr;
   logic             cur_wr_en;
   logic [IW-1:0]    cur_wr_addr;
   logic [CUR_W-1:0] cur_wr_data;

   assign eff_count  = (count_ff > MAX_CNT) ? MAX_CNT : count_ff;
   assign req_tready = !(walk_ff || rd_valid_ff || ev_valid_ff || mul_valid_ff);
   assign req_accept = req_tvalid && req_tready;
   assign is_channel = req_accept && (req_tuser == CMD_CHANNEL);
   assign is_tick    = req_accept && (req_tuser == CMD_TICK);
   assign motor_ok   = req_select && ({1'b0, req_motor} < eff_count);
   assign adv        = !out_valid_ff || rsp_tready;
   assign issue      = walk_ff && active_ff[idx_ff[IW-1:0]];

   // is any active motor still ahead of the walk
   always_comb begin
      later_active = 1'b0;
      for (int j = 0; j < MAX_MOTORS; j++) begin
         if (active_ff[j] && (CNT_W'(j) > idx_ff) && (CNT_W'(j) < eff_count)) begin
            later_active = 1'b1;
         end
      end
   end

   always_comb begin
      active_in  = active_ff;
      started_in = started_ff;
      if (is_channel) begin
         if (req_frame_start) active_in = '0;
         if (motor_ok) begin
            active_in[req_motor[IW-1:0]]  = 1'b1;
            started_in[req_motor[IW-1:0]] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= CNT_RESET;
         active_ff  <= '0;
         started_ff <= '0;
      end else begin
         if (csr_wr_en) count_ff <= csr_wr_data;
         active_ff  <= active_in;
         started_ff <= started_in;
      end
   end

   // motor walk
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (is_tick) begin
         walk_ff <= (eff_count != '0);
         idx_ff  <= '0;
      end else if (walk_ff && adv) begin
         idx_ff <= idx_ff + CNT_W'(1);
         if (idx_ff + CNT_W'(1) == eff_count) walk_ff <= 1'b0;
      end
   end

   // state rams: target with dial, and current value
   mfs_ram #(
      .WIDTH (TD_W),
      .DEPTH (MAX_MOTORS)
   ) u_td_ram (
      .clock   (clock),
      .wr_en   (is_channel && motor_ok),
      .wr_addr (req_motor[IW-1:0]),
      .wr_data ({req_dial, req_fader}),
      .rd_en   (issue && adv),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (td_rd_data)
   );

   assign ch_cur_wr   = is_channel && motor_ok && !started_ff[req_motor[IW-1:0]];
   assign wb_en       = mul_valid_ff && adv;
   assign cur_wr_en   = ch_cur_wr || wb_en;
   assign cur_wr_addr = wb_en ? mul_idx_ff : req_motor[IW-1:0];
   assign cur_wr_data = wb_en ? new_cur : {req_fader, FRAC_BITS'(0)};

   mfs_ram #(
      .WIDTH (CUR_W),
      .DEPTH (MAX_MOTORS)
   ) u_cur_ram (
      .clock   (clock),
      .wr_en   (cur_wr_en),
      .wr_addr (cur_wr_addr),
      .wr_data (cur_wr_data),
      .rd_en   (issue && adv),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (cur_rd_data)
   );

   // evaluate: error magnitude, direction, snap and alpha lookup
   always_comb begin
      ev_tgt_in  = {td_rd_data[FADER_W-1:0], FRAC_BITS'(0)};
      alpha_rd   = ALPHA_ROM[td_rd_data[TD_W-1:FADER_W]*ALPHA_W +: ALPHA_W];
      ev_up_in   = ev_tgt_in >= cur_rd_data;
      ev_mag_in  = ev_up_in ? (ev_tgt_in - cur_rd_data) : (cur_rd_data - ev_tgt_in);
      ev_snap_in = (ev_mag_in <= HALF_LSB) || (alpha_rd == ALPHA_ONE);
   end

   // write-back: step toward target, then round and clamp
   always_comb begin
      step_sum  = {1'b0, mul_prod_ff} + ALPHA_HALF;
      step      = step_sum[PROD_W:ALPHA_FRAC];
      if (mul_snap_ff) begin
         new_cur = mul_tgt_ff;
      end else if (mul_up_ff) begin
         new_cur = CUR_W'({1'b0, mul_cur_ff} + step);
      end else begin
         new_cur = CUR_W'({1'b0, mul_cur_ff} - step);
      end
      round_sum  = {1'b0, new_cur} + {1'b0, HALF_LSB};
      rounded    = round_sum[CUR_W:FRAC_BITS];
      out_val_in = rounded[FADER_W] ? FADER_MAX : rounded[FADER_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         ev_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         rd_valid_ff  <= issue;
         ev_valid_ff  <= rd_valid_ff;
         mul_valid_ff <= ev_valid_ff;
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_idx_ff   <= idx_ff[IW-1:0];
         rd_last_ff  <= !later_active;

         ev_idx_ff   <= rd_idx_ff;
         ev_last_ff  <= rd_last_ff;
         ev_tgt_ff   <= ev_tgt_in;
         ev_cur_ff   <= cur_rd_data;
         ev_mag_ff   <= ev_mag_in;
         ev_up_ff    <= ev_up_in;
         ev_snap_ff  <= ev_snap_in;
         ev_alpha_ff <= alpha_rd[ALPHA_FRAC-1:0];

         mul_idx_ff  <= ev_idx_ff;
         mul_last_ff <= ev_last_ff;
         mul_tgt_ff  <= ev_tgt_ff;
         mul_cur_ff  <= ev_cur_ff;
         mul_up_ff   <= ev_up_ff;
         mul_snap_ff <= ev_snap_ff;
         mul_prod_ff <= ev_mag_ff * ev_alpha_ff;

         out_idx_ff  <= MOTOR_W'(mul_idx_ff);
         out_val_ff  <= out_val_in;
         out_last_ff <= mul_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {(RSP_W - MOTOR_W - FADER_W)'(0), out_val_ff, out_idx_ff};

   `MFS_ASSERT_IMP(a_last_drains, clock, reset, out_valid_ff && out_last_ff, !rd_valid_ff && !ev_valid_ff && !mul_valid_ff, "result after last of tick")
   `MFS_ASSERT_IMP(a_wb_idle, clock, reset, mul_valid_ff, !req_accept, "transfer taken during write-back")
   `MFS_ASSERT_NEXT(a_empty_tick, clock, reset, is_tick && (eff_count == '0), req_tready, "tick with no motors kept block busy")

endmodule

`default_nettype wire
